/* design/slt_pkg.sv */
`timescale 1ns / 1ps

package slt_pkg;

    // operation codes
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CHECK  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_INVALID   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    // highest id that a check accepts
    localparam logic [7:0] LAST_VALID_ID = 8'd254;

    // one record of the limit table
    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] lim_min;
        logic signed [15:0] lim_max;
    } entry_t;

    // result of one item
    typedef struct packed {
        logic               in_range;
        logic               above_max;
        logic               below_min;
        logic [1:0]         status;
        logic signed [15:0] min_limit;
        logic signed [15:0] max_limit;
    } result_t;

endpackage

/* design/servo_angle_limit_table.sv */
`timescale 1ns / 1ps

// Servo angle limit table. Holds up to TABLE_ENTRIES records of (servo id,
// minimum, maximum) in one synchronous memory, filled in order of first set.
// Op 0 sets limits (overwrite or append; a full table answers status 3),
// op 1 checks an angle against the stored limits, op 2 reads them back; angles
// are signed 16-bit in 1/64 degree. Each item searches the records one per
// cycle through the single read port of the memory; an op 3, a check of id 255
// or any item on an empty table goes straight to its result without a search.
// One item is worked on at a time; the next transfer can be taken while the
// previous result still waits in the output register.
module servo_angle_limit_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [7:0]         servo_id,
    input  logic signed [15:0] angle,
    input  logic signed [15:0] new_min,
    input  logic signed [15:0] new_max,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               in_range,
    output logic               above_max,
    output logic               below_min,
    output logic [1:0]         status,
    output logic signed [15:0] min_limit,
    output logic signed [15:0] max_limit
);

    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic [CNTW-1:0]        count_reg;
    logic [CNTW-1:0]        idx_reg;
    logic                   pend_reg;
    logic [IDXW-1:0]        pidx_reg;
    logic                   found_reg;
    logic [IDXW-1:0]        slot_reg;
    logic signed [15:0]     hit_min_reg;
    logic signed [15:0]     hit_max_reg;

    logic [1:0]             op_reg;
    logic [7:0]             id_reg;
    logic signed [15:0]     angle_reg;
    logic signed [15:0]     nmin_reg;
    logic signed [15:0]     nmax_reg;

    logic                   out_valid_reg;
    slt_pkg::result_t       out_reg;

    slt_pkg::entry_t        mem [TABLE_ENTRIES];
    slt_pkg::entry_t        rd_data_reg;

    logic                   issue;
    logic                   hit;
    logic                   full;
    logic                   out_load;
    logic                   mem_we;
    logic [IDXW-1:0]        mem_wa;
    slt_pkg::entry_t        mem_wd;
    logic                   mem_re;
    slt_pkg::result_t       res;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    // scan control
    assign issue  = (idx_reg < count_reg);
    assign mem_re = (state_reg == ST_SCAN) && issue;
    assign hit    = pend_reg && (rd_data_reg.id == id_reg);
    assign full   = (count_reg == CNTW'(TABLE_ENTRIES));

    // write back of a set: overwrite the found record or append
    assign mem_we = out_load && (op_reg == slt_pkg::OP_SET) && (found_reg || !full);
    assign mem_wa = found_reg ? slot_reg : count_reg[IDXW-1:0];
    always_comb
    begin
        mem_wd.id      = id_reg;
        mem_wd.lim_min = nmin_reg;
        mem_wd.lim_max = nmax_reg;
    end

    // result of the item
    always_comb
    begin
        res = '0;
        unique case (op_reg)
            slt_pkg::OP_SET:
            begin
                res.status = (!found_reg && full) ? slt_pkg::STATUS_FULL
                                                  : slt_pkg::STATUS_OK;
            end
            slt_pkg::OP_CHECK:
            begin
                if (id_reg > slt_pkg::LAST_VALID_ID)
                begin
                    res.status = slt_pkg::STATUS_INVALID;
                end
                else if (!found_reg)
                begin
                    res.status = slt_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    res.above_max = (angle_reg > hit_max_reg);
                    res.below_min = (angle_reg < hit_min_reg);
                    res.in_range  = !res.above_max && !res.below_min;
                end
            end
            slt_pkg::OP_READ:
            begin
                if (!found_reg)
                begin
                    res.status = slt_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    res.min_limit = hit_min_reg;
                    res.max_limit = hit_max_reg;
                end
            end
            slt_pkg::OP_UNUSED:
            begin
                res = '0;
            end
        endcase
    end

    // record memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[idx_reg[IDXW-1:0]];
        end
    end

    // sequencer, item registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pidx_reg      <= '0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            hit_min_reg   <= '0;
            hit_max_reg   <= '0;
            op_reg        <= slt_pkg::OP_SET;
            id_reg        <= '0;
            angle_reg     <= '0;
            nmin_reg      <= '0;
            nmax_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // output register drains independently
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op;
                        id_reg    <= servo_id;
                        angle_reg <= angle;
                        nmin_reg  <= new_min;
                        nmax_reg  <= new_max;
                        found_reg <= 1'b0;
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        if ((count_reg == '0) || (op == slt_pkg::OP_UNUSED) ||
                            ((op == slt_pkg::OP_CHECK) && (servo_id > slt_pkg::LAST_VALID_ID)))
                        begin
                            state_reg <= ST_RESULT;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // read one record a cycle, compare the one read last cycle
                    pend_reg <= issue;
                    pidx_reg <= idx_reg[IDXW-1:0];
                    if (issue)
                    begin
                        idx_reg <= idx_reg + CNTW'(1);
                    end
                    if (hit)
                    begin
                        found_reg   <= 1'b1;
                        slot_reg    <= pidx_reg;
                        hit_min_reg <= rd_data_reg.lim_min;
                        hit_max_reg <= rd_data_reg.lim_max;
                        state_reg   <= ST_RESULT;
                    end
                    else if (pend_reg && !issue)
                    begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (out_load)
                    begin
                        if ((op_reg == slt_pkg::OP_SET) && !found_reg && !full)
                        begin
                            count_reg <= count_reg + CNTW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result fields
    assign in_range  = out_reg.in_range;
    assign above_max = out_reg.above_max;
    assign below_min = out_reg.below_min;
    assign status    = out_reg.status;
    assign min_limit = out_reg.min_limit;
    assign max_limit = out_reg.max_limit;

`ifndef NO_ASSERTIONS
    // the fill count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // the fill count grows by at most one per cycle and never shrinks
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("entry count moved by more than one");

    // a compared record always lies below the fill count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && pend_reg |-> ({1'b0, pidx_reg} < {1'b0, count_reg}))
        else $error("scan compared an unfilled record");

    // an accepted transfer always starts work on the item
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> (state_reg != ST_IDLE))
        else $error("accepted transfer left the sequencer idle");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 20;
    localparam int ITEMS_PER_PHASE = 160;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [7:0]         servo_id;
    logic signed [15:0] angle;
    logic signed [15:0] new_min;
    logic signed [15:0] new_max;
    logic               out_valid;
    logic               out_stall;
    logic               in_range;
    logic               above_max;
    logic               below_min;
    logic [1:0]         status;
    logic signed [15:0] min_limit;
    logic signed [15:0] max_limit;

    // percentages of idle cycles on each side
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;

    // servo ids that most random commands pick from
    logic [7:0] id_pool [POOL_SIZE];

    // mirror of the limit table plus the answers still owed by the block
    class limit_scoreboard;
        logic [7:0]         known_id  [TABLE_DEPTH];
        logic signed [15:0] known_min [TABLE_DEPTH];
        logic signed [15:0] known_max [TABLE_DEPTH];
        int unsigned        known_count = 0;
        slt_pkg::result_t   pending_answers [$];
        int                 mismatch_count = 0;

        // index of the record for an id, or -1 when absent
        function int slot_of(logic [7:0] id_v);
            for (int i = 0; i < known_count; i++)
            begin
                if (known_id[i] == id_v)
                    return i;
            end
            return -1;
        endfunction

        // work out the answer to one accepted command and update the mirror
        function void note_command(logic [1:0] op_v, logic [7:0] id_v,
                                   logic signed [15:0] angle_v,
                                   logic signed [15:0] min_v,
                                   logic signed [15:0] max_v);
            slt_pkg::result_t answer;
            int               slot;
            answer = '0;
            slot = slot_of(id_v);
            case (op_v)
                slt_pkg::OP_SET:
                begin
                    if (slot >= 0)
                    begin
                        known_min[slot] = min_v;
                        known_max[slot] = max_v;
                    end
                    else if (known_count < TABLE_DEPTH)
                    begin
                        known_id[known_count]  = id_v;
                        known_min[known_count] = min_v;
                        known_max[known_count] = max_v;
                        known_count++;
                    end
                    else
                        answer.status = slt_pkg::STATUS_FULL;
                end
                slt_pkg::OP_CHECK:
                begin
                    if (id_v > slt_pkg::LAST_VALID_ID)
                        answer.status = slt_pkg::STATUS_INVALID;
                    else if (slot < 0)
                        answer.status = slt_pkg::STATUS_NOT_FOUND;
                    else
                    begin
                        answer.above_max = (angle_v > known_max[slot]);
                        answer.below_min = (angle_v < known_min[slot]);
                        answer.in_range  = !answer.above_max && !answer.below_min;
                    end
                end
                slt_pkg::OP_READ:
                begin
                    if (slot < 0)
                        answer.status = slt_pkg::STATUS_NOT_FOUND;
                    else
                    begin
                        answer.min_limit = known_min[slot];
                        answer.max_limit = known_max[slot];
                    end
                end
                default:
                    answer = '0;
            endcase
            pending_answers = {pending_answers, answer};
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
                mismatch_count++;
            end
        endfunction

        // compare one result transfer with the oldest answer owed
        function void check_answer(slt_pkg::result_t seen);
            slt_pkg::result_t want;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, seen);
                mismatch_count++;
                return;
            end
            want = pending_answers.pop_front();
            compare_field("in_range",  16'(want.in_range),  16'(seen.in_range));
            compare_field("above_max", 16'(want.above_max), 16'(seen.above_max));
            compare_field("below_min", 16'(want.below_min), 16'(seen.below_min));
            compare_field("status",    16'(want.status),    16'(seen.status));
            compare_field("min_limit", want.min_limit,      seen.min_limit);
            compare_field("max_limit", want.max_limit,      seen.max_limit);
        endfunction
    endclass

    limit_scoreboard sb = new();

    servo_angle_limit_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .servo_id  (servo_id),
        .angle     (angle),
        .new_min   (new_min),
        .new_max   (new_max),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .in_range  (in_range),
        .above_max (above_max),
        .below_min (below_min),
        .status    (status),
        .min_limit (min_limit),
        .max_limit (max_limit)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver stalls at random
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        slt_pkg::result_t seen;
        seen = {in_range, above_max, below_min, status, min_limit, max_limit};
        if (rst_n && out_valid && !out_stall)
            sb.check_answer(seen);
    end

    // drive one command and wait for its transfer
    task automatic send_command(logic [1:0] op_v, logic [7:0] id_v,
                                logic signed [15:0] angle_v,
                                logic signed [15:0] min_v,
                                logic signed [15:0] max_v);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_v;
        servo_id <= id_v;
        angle    <= angle_v;
        new_min  <= min_v;
        new_max  <= max_v;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(op_v, id_v, angle_v, min_v, max_v);
    endtask

    // drop valid after the last transfer and wait for every answer
    task automatic drain_answers();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // one random command, mostly on ids from the id pool
    task automatic random_command();
        int                 pick;
        int                 slot;
        logic [1:0]         op_v;
        logic [7:0]         id_v;
        logic signed [15:0] angle_v;
        logic signed [15:0] min_v;
        logic signed [15:0] max_v;
        logic signed [15:0] edge_v;

        pick = $urandom_range(0, 99);
        if (pick < 35)
            op_v = slt_pkg::OP_SET;
        else if (pick < 75)
            op_v = slt_pkg::OP_CHECK;
        else if (pick < 95)
            op_v = slt_pkg::OP_READ;
        else
            op_v = slt_pkg::OP_UNUSED;

        pick = $urandom_range(0, 99);
        if (pick < 80)
            id_v = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 92)
            id_v = 8'($urandom_range(0, 255));
        else
            id_v = 8'd255;

        // limits: mostly ordered and modest, sometimes anything at all
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            min_v = 16'($urandom_range(0, 4000) - 2000);
            max_v = min_v + 16'($urandom_range(0, 3000));
        end
        else if (pick < 8)
        begin
            min_v = 16'($urandom);
            max_v = 16'($urandom);
        end
        else
        begin
            min_v = ($urandom_range(0, 1) != 0) ? -16'sd32768 : 16'($urandom);
            max_v = ($urandom_range(0, 1) != 0) ? 16'sd32767 : 16'($urandom);
        end

        // angle: often at or near a stored limit
        slot = sb.slot_of(id_v);
        if (slot >= 0 && $urandom_range(0, 2) != 0)
        begin
            edge_v  = ($urandom_range(0, 1) != 0) ? sb.known_min[slot] : sb.known_max[slot];
            angle_v = edge_v + 16'($urandom_range(0, 4)) - 16'sd2;
        end
        else
            angle_v = 16'($urandom);

        send_command(op_v, id_v, angle_v, min_v, max_v);
    endtask

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = slt_pkg::OP_SET;
        servo_id       = '0;
        angle          = '0;
        new_min        = '0;
        new_max        = '0;
        send_gap_pct   = 8;
        recv_stall_pct = 52;
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = 8'($urandom_range(0, 254));
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, invalid id, extremes, overwrite, inverted limits
        send_command(slt_pkg::OP_UNUSED, 8'h5a, 16'sh1234, 16'sh5678, -16'sd1);
        send_command(slt_pkg::OP_CHECK,  8'd3,   16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_READ,   8'd3,   16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd255, 16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_SET,    8'd255, 16'sd0, -16'sd32768, 16'sd32767);
        send_command(slt_pkg::OP_READ,   8'd255, 16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd255, 16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_SET,    8'd0,   16'sd0, -16'sd32768, 16'sd32767);
        send_command(slt_pkg::OP_CHECK,  8'd0,   -16'sd32768, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd0,   16'sd32767, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_SET,    8'd0,   16'sd0, -16'sd64, 16'sd64);
        send_command(slt_pkg::OP_READ,   8'd0,   16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd0,   16'sd64, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd0,   16'sd65, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd0,   -16'sd65, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_SET,    8'd254, 16'sd0, 16'sd100, -16'sd100);
        send_command(slt_pkg::OP_CHECK,  8'd254, 16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd254, 16'sd200, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_CHECK,  8'd254, -16'sd200, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_SET,    8'd1,   16'sd0, 16'sd32767, -16'sd32768);
        send_command(slt_pkg::OP_CHECK,  8'd1,   16'sd0, 16'sd0, 16'sd0);
        send_command(slt_pkg::OP_UNUSED, 8'hff,  -16'sd1, -16'sd1, -16'sd1);

        // random phases with changing idle patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct   = 8;
                    recv_stall_pct = 52;
                end
                1:
                begin
                    send_gap_pct   = 52;
                    recv_stall_pct = 8;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) random_command();
            // hold off until the block has answered everything
            if (phase == 0)
                drain_answers();
        end

        drain_answers();
        repeat (40) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending_answers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/slt_pkg.sv
design/servo_angle_limit_table.sv
bench/tb_top.sv
